>>> rtl/core/sdci_pkg.sv
// ----------------------------------------------------------------------------
// sdci_pkg
// Shared types, command codes and constants of the SD card init sequencer.
// ----------------------------------------------------------------------------
package sdci_pkg;

  localparam int unsigned RetryW      = 17;
  localparam logic [RetryW-1:0] RetryLimit = 17'd100000;
  localparam int unsigned SectorBytes = 512;
  localparam int unsigned SectorShift = $clog2(SectorBytes);
  localparam int unsigned CsdV2Unit   = 1024;
  localparam int unsigned CsdV2Shift  = $clog2(CsdV2Unit);
  localparam int unsigned VoltW       = 24;
  localparam logic [VoltW-1:0] VoltWinReset = 24'hFF8000;
  localparam logic [11:0] IfCheckPattern = 12'h1AA;
  localparam logic [31:0] OcrHcs = 32'h4000_0000;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_CMD55  = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD2   = 4'd5,
    PH_CMD3   = 4'd6,
    PH_CMD9   = 4'd7,
    PH_CMD7   = 4'd8,
    PH_CMD16  = 4'd9,
    PH_CLOCK  = 4'd10,
    PH_READY  = 4'd11,
    PH_XFER   = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RESP  = 2'd1,
    REQ_XFER  = 2'd2,
    REQ_NOP   = 2'd3
  } req_cmd_e;

  localparam logic [1:0] ST_WORKING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_BUSY  = 2'd2;
  localparam logic [1:0] RK_LONG  = 2'd3;

  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
  localparam logic [5:0] CMD_SELECT       = 6'd7;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] ACMD_OP_COND     = 6'd41;
  localparam logic [5:0] CMD_APP          = 6'd55;

  typedef struct packed {
    logic        issue;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [1:0]  kind;
    logic        crc;
    logic        chk;
    logic        data;
  } sd_cmd_t;

  typedef struct packed {
    logic        fmt_ok;
    logic        nonzero;
    logic [32:0] blocks;
  } csd_info_t;

  function automatic sd_cmd_t make_cmd(logic [5:0] idx, logic [31:0] arg, logic [1:0] kind,
                                       logic crc, logic chk, logic data);
    sd_cmd_t c;
    c.issue = 1'b1;
    c.idx   = idx;
    c.arg   = arg;
    c.kind  = kind;
    c.crc   = crc;
    c.chk   = chk;
    c.data  = data;
    return c;
  endfunction

endpackage

>>> rtl/core/sdci_if.sv
// ----------------------------------------------------------------------------
// sdci_req_if / sdci_rsp_if
// Valid/ready channels for request beats and command result beats.
// ----------------------------------------------------------------------------
interface sdci_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        host_failed;
  logic [63:0] resp_low;
  logic [63:0] resp_high;
  logic [63:0] start_lba;
  logic [31:0] block_total;
  logic        write_access;

  modport source (output valid, cmd, host_failed, resp_low, resp_high, start_lba,
                  block_total, write_access, input ready);
  modport sink   (input valid, cmd, host_failed, resp_low, resp_high, start_lba,
                  block_total, write_access, output ready);
endinterface

interface sdci_rsp_if;
  logic        valid;
  logic        ready;
  logic        issue;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_argument;
  logic [1:0]  resp_kind;
  logic        check_crc;
  logic        check_index;
  logic        has_data;
  logic        clock_switch;
  logic [1:0]  status;
  logic [32:0] capacity_blocks;
  logic        is_high_capacity;

  modport source (output valid, issue, cmd_index, cmd_argument, resp_kind, check_crc,
                  check_index, has_data, clock_switch, status, capacity_blocks,
                  is_high_capacity, input ready);
  modport sink   (input valid, issue, cmd_index, cmd_argument, resp_kind, check_crc,
                  check_index, has_data, clock_switch, status, capacity_blocks,
                  is_high_capacity, output ready);
endinterface

>>> rtl/core/sdci_csd_dec.sv
// ----------------------------------------------------------------------------
// sdci_csd_dec
// Decodes a CSD v1 or v2 long response into a card size in sectors.
// ----------------------------------------------------------------------------
module sdci_csd_dec
  import sdci_pkg::*;
(
  input  logic [63:0] resp_low_i,
  input  logic [63:0] resp_high_i,
  output csd_info_t   info_o
);

  logic [127:0] raw;
  logic [1:0]   csd_struct;
  logic [21:0]  v2_size;
  logic [3:0]   read_bl_len;
  logic [11:0]  v1_size;
  logic [2:0]   size_mult;
  logic [4:0]   v1_shift;
  logic [36:0]  v1_bytes;
  logic [32:0]  v1_blocks;
  logic [32:0]  v2_blocks;
  logic [32:0]  blocks;
  logic         fmt_ok;

  // CSD bit b sits at raw[b-8]: the CRC byte is stripped
  assign raw         = {resp_high_i, resp_low_i};
  assign csd_struct  = raw[119:118];
  assign v2_size     = raw[61:40];
  assign read_bl_len = raw[75:72];
  assign v1_size     = raw[65:54];
  assign size_mult   = raw[41:39];

  assign v1_shift  = 5'(size_mult) + 5'd2 + 5'(read_bl_len);
  assign v1_bytes  = 37'({1'b0, v1_size} + 13'd1) << v1_shift;
  assign v1_blocks = 33'(v1_bytes >> SectorShift);
  assign v2_blocks = 33'({1'b0, v2_size} + 23'd1) << CsdV2Shift;

  always_comb begin
    unique case (csd_struct)
      2'b00: begin
        fmt_ok = 1'b1;
        blocks = v1_blocks;
      end
      2'b01: begin
        fmt_ok = 1'b1;
        blocks = v2_blocks;
      end
      default: begin
        fmt_ok = 1'b0;
        blocks = '0;
      end
    endcase
  end

  assign info_o.fmt_ok  = fmt_ok;
  assign info_o.nonzero = (blocks != '0);
  assign info_o.blocks  = blocks;

endmodule

>>> rtl/core/sd_card_init_and_block_addressing.sv
// ----------------------------------------------------------------------------
// sd_card_init_and_block_addressing
// SD card bring-up and single-block transfer command sequencer.
// ----------------------------------------------------------------------------
// Each accepted request beat is registered; its result beat is valid in the cycle after acceptance.
// Throughput: one beat per cycle; a new request is taken while the result
// register is empty or being drained in the same cycle.
// Reset: rst_ni clears phase, card data, transfer state and the output valid;
// the voltage window returns to 0xFF8000.
module sd_card_init_and_block_addressing
  import sdci_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [VoltW-1:0]  cfg_wdata_i,
  sdci_req_if.sink          req_i,
  sdci_rsp_if.source        rsp_o
);

  phase_e             phase_q, phase_d;
  logic [RetryW-1:0]  retry_q, retry_d;
  logic [15:0]        rca_q, rca_d;
  logic               high_cap_q, high_cap_d;
  logic [32:0]        card_blocks_q, card_blocks_d;
  logic               ready_q, ready_d;
  logic [63:0]        next_lba_q, next_lba_d;
  logic [31:0]        blocks_left_q, blocks_left_d;
  logic               dir_q, dir_d;
  logic [VoltW-1:0]   volt_q;

  logic               out_valid_q;
  sd_cmd_t            out_cmd_q, cmd_d;
  logic               out_clk_q, clk_sw_d;
  logic [1:0]         out_status_q, status_d;

  csd_info_t          csd;
  logic               fire;
  logic               xfer_req;
  logic [31:0]        r32;
  logic [RetryW-1:0]  retry_inc;
  logic [63:0]        blk_lba;
  logic               blk_dir;
  logic [31:0]        blk_left;
  logic               blk_ok;
  logic [31:0]        blk_addr;
  sd_cmd_t            blk_cmd;
  logic               init_err;

  sdci_csd_dec u_csd_dec (
    .resp_low_i  (req_i.resp_low),
    .resp_high_i (req_i.resp_high),
    .info_o      (csd)
  );

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign r32         = req_i.resp_low[31:0];
  assign retry_inc   = retry_q + 1'b1;

  // Block command: a new request takes its fields from the beat, later blocks from state
  assign xfer_req = (req_i.cmd == REQ_XFER);
  assign blk_lba  = xfer_req ? req_i.start_lba : next_lba_q;
  assign blk_dir  = xfer_req ? req_i.write_access : dir_q;
  assign blk_left = xfer_req ? req_i.block_total : blocks_left_q;
  assign blk_ok   = high_cap_q ? (blk_lba[63:32] == '0)
                               : (blk_lba[63:32-SectorShift] == '0);
  assign blk_addr = high_cap_q ? blk_lba[31:0] : 32'(blk_lba[31:0] << SectorShift);
  assign blk_cmd  = make_cmd(blk_dir ? CMD_WRITE_SINGLE : CMD_READ_SINGLE, blk_addr,
                             RK_SHORT, 1'b1, 1'b1, 1'b1);

  always_comb begin
    phase_d       = phase_q;
    retry_d       = retry_q;
    rca_d         = rca_q;
    high_cap_d    = high_cap_q;
    card_blocks_d = card_blocks_q;
    ready_d       = ready_q;
    next_lba_d    = next_lba_q;
    blocks_left_d = blocks_left_q;
    dir_d         = dir_q;
    cmd_d         = '0;
    clk_sw_d      = 1'b0;
    status_d      = ST_WORKING;
    init_err      = 1'b0;

    if (fire) begin
      unique case (req_cmd_e'(req_i.cmd))
        REQ_START: begin
          rca_d         = '0;
          card_blocks_d = '0;
          high_cap_d    = 1'b0;
          ready_d       = 1'b0;
          next_lba_d    = '0;
          blocks_left_d = '0;
          retry_d       = '0;
          if (req_i.host_failed) begin
            init_err = 1'b1;
          end else begin
            cmd_d   = make_cmd(CMD_GO_IDLE, '0, RK_NONE, 1'b0, 1'b0, 1'b0);
            phase_d = PH_CMD0;
          end
        end
        REQ_XFER: begin
          if (phase_q != PH_READY || !ready_q || req_i.block_total == '0) begin
            status_d = ST_ERROR;
          end else begin
            next_lba_d = req_i.start_lba;
            dir_d      = req_i.write_access;
            if (blk_ok) begin
              cmd_d         = blk_cmd;
              next_lba_d    = blk_lba + 64'd1;
              blocks_left_d = blk_left - 32'd1;
              phase_d       = PH_XFER;
            end else begin
              blocks_left_d = '0;
              status_d      = ST_ERROR;
            end
          end
        end
        REQ_RESP: begin
          if (req_i.host_failed && phase_q >= PH_CMD0 && phase_q <= PH_CLOCK) begin
            init_err = 1'b1;
          end else begin
            unique case (phase_q)
              PH_CMD0: begin
                cmd_d   = make_cmd(CMD_SEND_IF_COND, 32'(IfCheckPattern), RK_SHORT,
                                   1'b1, 1'b1, 1'b0);
                phase_d = PH_CMD8;
              end
              PH_CMD8: begin
                if (r32[11:0] != IfCheckPattern) begin
                  init_err = 1'b1;
                end else begin
                  retry_d = '0;
                  cmd_d   = make_cmd(CMD_APP, {rca_q, 16'h0}, RK_SHORT, 1'b1, 1'b1, 1'b0);
                  phase_d = PH_CMD55;
                end
              end
              PH_CMD55: begin
                cmd_d   = make_cmd(ACMD_OP_COND, OcrHcs | 32'(volt_q), RK_SHORT,
                                   1'b0, 1'b0, 1'b0);
                phase_d = PH_ACMD41;
              end
              PH_ACMD41: begin
                if (r32[31]) begin
                  high_cap_d = r32[30];
                  cmd_d      = make_cmd(CMD_ALL_SEND_CID, '0, RK_LONG, 1'b1, 1'b0, 1'b0);
                  phase_d    = PH_CMD2;
                end else begin
                  // card still busy: count the attempt and poll again, or fail at the retry limit
                  retry_d = retry_inc;
                  if (retry_inc >= RetryLimit) begin
                    init_err = 1'b1;
                  end else begin
                    cmd_d   = make_cmd(CMD_APP, {rca_q, 16'h0}, RK_SHORT,
                                       1'b1, 1'b1, 1'b0);
                    phase_d = PH_CMD55;
                  end
                end
              end
              PH_CMD2: begin
                cmd_d   = make_cmd(CMD_SEND_RCA, '0, RK_SHORT, 1'b1, 1'b1, 1'b0);
                phase_d = PH_CMD3;
              end
              PH_CMD3: begin
                rca_d = r32[31:16];
                if (r32[31:16] == '0) begin
                  init_err = 1'b1;
                end else begin
                  cmd_d   = make_cmd(CMD_SEND_CSD, {r32[31:16], 16'h0}, RK_LONG,
                                     1'b1, 1'b0, 1'b0);
                  phase_d = PH_CMD9;
                end
              end
              PH_CMD9: begin
                // size is kept even when zero; only a bad structure leaves it alone
                if (csd.fmt_ok) card_blocks_d = csd.blocks;
                if (!(csd.fmt_ok && csd.nonzero)) begin
                  init_err = 1'b1;
                end else begin
                  cmd_d   = make_cmd(CMD_SELECT, {rca_q, 16'h0}, RK_BUSY, 1'b1, 1'b1, 1'b0);
                  phase_d = PH_CMD7;
                end
              end
              PH_CMD7: begin
                if (!high_cap_q) begin
                  cmd_d   = make_cmd(CMD_SET_BLOCKLEN, 32'(SectorBytes), RK_SHORT,
                                     1'b1, 1'b1, 1'b0);
                  phase_d = PH_CMD16;
                end else begin
                  clk_sw_d = 1'b1;
                  phase_d  = PH_CLOCK;
                end
              end
              PH_CMD16: begin
                clk_sw_d = 1'b1;
                phase_d  = PH_CLOCK;
              end
              PH_CLOCK: begin
                ready_d  = 1'b1;
                status_d = ST_DONE;
                phase_d  = PH_READY;
              end
              PH_XFER: begin
                if (req_i.host_failed || (blocks_left_q != '0 && !blk_ok)) begin
                  status_d      = ST_ERROR;
                  blocks_left_d = '0;
                  phase_d       = PH_READY;
                end else if (blocks_left_q == '0) begin
                  status_d = ST_DONE;
                  phase_d  = PH_READY;
                end else begin
                  cmd_d         = blk_cmd;
                  next_lba_d    = blk_lba + 64'd1;
                  blocks_left_d = blk_left - 32'd1;
                end
              end
              default: begin
                status_d = ST_ERROR;
              end
            endcase
          end
        end
        REQ_NOP: begin
          status_d = ST_WORKING;
        end
      endcase

      if (init_err) begin
        cmd_d    = '0;
        clk_sw_d = 1'b0;
        status_d = ST_ERROR;
        ready_d  = 1'b0;
        phase_d  = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      retry_q       <= '0;
      rca_q         <= '0;
      high_cap_q    <= 1'b0;
      card_blocks_q <= '0;
      ready_q       <= 1'b0;
      next_lba_q    <= '0;
      blocks_left_q <= '0;
      dir_q         <= 1'b0;
      volt_q        <= VoltWinReset;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      retry_q       <= retry_d;
      rca_q         <= rca_d;
      high_cap_q    <= high_cap_d;
      card_blocks_q <= card_blocks_d;
      ready_q       <= ready_d;
      next_lba_q    <= next_lba_d;
      blocks_left_q <= blocks_left_d;
      dir_q         <= dir_d;
      if (cfg_we_i) volt_q <= cfg_wdata_i;
      // hold the result beat until taken
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_cmd_q    <= cmd_d;
      out_clk_q    <= clk_sw_d;
      out_status_q <= status_d;
    end
  end

  // capacity and addressing mode are registered state, shown in every beat
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.issue            = out_cmd_q.issue;
  assign rsp_o.cmd_index        = out_cmd_q.idx;
  assign rsp_o.cmd_argument     = out_cmd_q.arg;
  assign rsp_o.resp_kind        = out_cmd_q.kind;
  assign rsp_o.check_crc        = out_cmd_q.crc;
  assign rsp_o.check_index      = out_cmd_q.chk;
  assign rsp_o.has_data         = out_cmd_q.data;
  assign rsp_o.clock_switch     = out_clk_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.capacity_blocks  = card_blocks_q;
  assign rsp_o.is_high_capacity = high_cap_q;

endmodule

>>> rtl/core/sdci_chk.sv
// ----------------------------------------------------------------------------
// sdci_chk
// Port-level checks on the result channel of the command sequencer.
// ----------------------------------------------------------------------------
module sdci_chk
  import sdci_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        issue_i,
  input logic [5:0]  cmd_index_i,
  input logic [31:0] cmd_argument_i,
  input logic [1:0]  resp_kind_i,
  input logic        check_crc_i,
  input logic        check_index_i,
  input logic        has_data_i,
  input logic        clock_switch_i,
  input logic [1:0]  status_i
);

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(issue_i) && $stable(cmd_argument_i)
      && $stable(cmd_index_i) && $stable(status_i))
    else $error("result beat changed while stalled");

  a_no_issue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !issue_i |-> cmd_index_i == '0 && cmd_argument_i == '0
      && resp_kind_i == RK_NONE && !check_crc_i && !check_index_i && !has_data_i)
    else $error("command fields set without issue");

  a_issue_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (issue_i || clock_switch_i) |-> status_i == ST_WORKING
      && !(issue_i && clock_switch_i))
    else $error("command or clock switch with a final status");

  a_data_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && has_data_i |-> resp_kind_i == RK_SHORT
      && (cmd_index_i == CMD_READ_SINGLE || cmd_index_i == CMD_WRITE_SINGLE))
    else $error("data block on a command that is no block transfer");

endmodule

bind sd_card_init_and_block_addressing sdci_chk u_sdci_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (rsp_o.valid),
  .ready_i        (rsp_o.ready),
  .issue_i        (rsp_o.issue),
  .cmd_index_i    (rsp_o.cmd_index),
  .cmd_argument_i (rsp_o.cmd_argument),
  .resp_kind_i    (rsp_o.resp_kind),
  .check_crc_i    (rsp_o.check_crc),
  .check_index_i  (rsp_o.check_index),
  .has_data_i     (rsp_o.has_data),
  .clock_switch_i (rsp_o.clock_switch),
  .status_i       (rsp_o.status)
);
